// ===== src/skst_pkg.sv =====
// Shared types and constants for the small key set table.
// No dependencies; imported by the sequencer, the top level and the testbench.
package skst_pkg;

  // Fixed field widths of the request and result ports
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Command codes; the unused code acts as a query
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    logic               is_member;
    status_e            status;
    logic [COUNT_W-1:0] entry_count;
  } res_t;

endpackage

// ===== src/small_key_set_table.sv =====
// Small unordered key set with swap-remove: insert, remove and membership
// query. Every request scans the held keys one per cycle through a single
// read port of the key memory and one comparator, stopping when the key is
// found; a successful remove then moves the last entry into the freed slot.
// The request side stalls while a request is in work; a finished result
// sits in an output register so the next request can be taken while it
// waits. Keys compare on their low KEY_BITS bits. Uses skst_pkg, skst_seq
// and skst_store.
module small_key_set_table
  import skst_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [KEY_W-1:0]    key_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                is_member_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [COUNT_W-1:0]  entry_count_o
);

  localparam int unsigned IDXW = $clog2(CAPACITY);
  localparam int unsigned CNTW = $clog2(CAPACITY + 1);

  logic                req_ready;
  logic                res_valid;
  logic                res_take;
  res_t                res;
  logic                wr_en;
  logic [IDXW-1:0]     wr_addr;
  logic [KEY_BITS-1:0] wr_data;
  logic                rd_en;
  logic [IDXW-1:0]     rd_addr;
  logic [KEY_BITS-1:0] rd_data;
  logic                out_valid_q;
  res_t                out_q;

  skst_seq #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .IDXW     (IDXW),
    .CNTW     (CNTW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (req_ready),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  skst_store #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_BITS),
    .AW    (IDXW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign in_stall_o = !req_ready;

  // Output register loads when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign is_member_o   = out_q.is_member;
  assign status_o      = out_q.status;
  assign entry_count_o = out_q.entry_count;

endmodule

// ===== src/skst_store.sv =====
// Key memory of the small key set table: one write port, one read port,
// registered read data. No package dependency.
module skst_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data valid the cycle after the read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/skst_seq.sv =====
// Sequencer of the small key set table: scans the key memory one entry per
// cycle with a single comparator, then updates it for an insert or remove. Uses skst_pkg.
module skst_seq
  import skst_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned IDXW     = 4,
  parameter int unsigned CNTW     = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request side
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [KEY_W-1:0]    key_i,
  // result side
  output logic                res_valid_o,
  input  logic                res_take_i,
  output res_t                res_o,
  // key memory
  output logic                wr_en_o,
  output logic [IDXW-1:0]     wr_addr_o,
  output logic [KEY_BITS-1:0] wr_data_o,
  output logic                rd_en_o,
  output logic [IDXW-1:0]     rd_addr_o,
  input  logic [KEY_BITS-1:0] rd_data_i
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_MOVE   = 5'b01000,
    S_RESP   = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [CNTW-1:0]     count_q, count_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [CNTW-1:0]     idx_q, idx_d;
  logic [IDXW-1:0]     cmp_idx_q, cmp_idx_d;
  logic [IDXW-1:0]     slot_q, slot_d;
  logic                present_q, present_d;
  status_e             status_q, status_d;
  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [CNTW-1:0]     last_idx;
  logic                hit;

  // Shared comparator: registered memory data against the request key
  assign hit      = cmp_vld_q && (rd_data_i == key_q);
  assign last_idx = count_q - CNTW'(1);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cmp_vld_d = 1'b0;
    idx_d     = idx_q;
    cmp_idx_d = cmp_idx_q;
    slot_d    = slot_q;
    present_d = present_q;
    status_d  = status_q;
    cmd_d     = cmd_q;
    key_d     = key_q;
    wr_en_o   = 1'b0;
    wr_addr_o = count_q[IDXW-1:0];
    wr_data_o = key_q;
    rd_en_o   = 1'b0;
    rd_addr_o = idx_q[IDXW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_d   = cmd_i;
          key_d   = KEY_BITS'(key_i);
          idx_d   = '0;
          state_d = S_SCAN;
        end
      end
      // one read issued and one compare done per cycle
      S_SCAN: begin
        if (hit) begin
          slot_d    = cmp_idx_q;
          present_d = 1'b1;
          state_d   = S_DECIDE;
        end else if (idx_q < count_q) begin
          rd_en_o   = 1'b1;
          rd_addr_o = idx_q[IDXW-1:0];
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q[IDXW-1:0];
          idx_d     = idx_q + CNTW'(1);
        end else begin
          present_d = 1'b0;
          state_d   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        status_d = ST_OK;
        state_d  = S_RESP;
        if (cmd_q == CMD_INSERT) begin
          if (present_q) begin
            status_d = ST_DUP;
          end else if (count_q == CNTW'(CAPACITY)) begin
            status_d = ST_FULL;
          end else begin
            // append at the end of the held entries
            wr_en_o   = 1'b1;
            wr_addr_o = count_q[IDXW-1:0];
            wr_data_o = key_q;
            count_d   = count_q + CNTW'(1);
          end
        end else if (cmd_q == CMD_REMOVE) begin
          if (!present_q) begin
            status_d = ST_ABSENT;
          end else begin
            // fetch the last entry to move into the freed slot
            rd_en_o   = 1'b1;
            rd_addr_o = last_idx[IDXW-1:0];
            state_d   = S_MOVE;
          end
        end
      end
      S_MOVE: begin
        wr_en_o   = 1'b1;
        wr_addr_o = slot_q;
        wr_data_o = rd_data_i;
        count_d   = last_idx;
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign req_ready_o       = (state_q == S_IDLE);
  assign res_valid_o       = (state_q == S_RESP);
  assign res_o.is_member   = present_q;
  assign res_o.status      = status_q;
  assign res_o.entry_count = COUNT_W'(count_q);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  // Request payload and scan bookkeeping
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    cmp_idx_q <= cmp_idx_d;
    slot_q    <= slot_d;
    present_q <= present_d;
    status_q  <= status_d;
    cmd_q     <= cmd_d;
    key_q     <= key_d;
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for small_key_set_table: sends insert, remove and query requests
// and checks each result against an in-bench model of the key set.
// Depends on skst_pkg and the small_key_set_table RTL.
module tb_top;
  import skst_pkg::*;

  localparam int unsigned SET_DEPTH = 16;
  // Unused command code, behaves as a query
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  // Comfortably above the worst request latency
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_DRAIN_WAIT = 20000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [CMD_W-1:0]    cmd_i;
  logic [KEY_W-1:0]    key_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                is_member_o;
  logic [STATUS_W-1:0] status_o;
  logic [COUNT_W-1:0]  entry_count_o;

  // Model of the set contents and results still owed by the block
  logic [KEY_W-1:0] held_keys [$];
  int unsigned      held_total = 0;
  res_t             outcome_fifo [$];
  int unsigned      fail_count = 0;

  // Sender burst and receiver stall pattern state
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_span = 0;
  int unsigned stall_tick = 0;

  always #5 clk_i = ~clk_i;

  small_key_set_table #(
    .CAPACITY(SET_DEPTH),
    .KEY_BITS(KEY_W)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .key_i        (key_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .is_member_o  (is_member_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o)
  );

  // Apply one request to the model set and return the result it produces
  function automatic res_t key_op_outcome(input logic [CMD_W-1:0] cmd,
                                          input logic [KEY_W-1:0] key);
    res_t        outcome;
    int unsigned slot;
    int unsigned idx;
    logic        found;
    found = 1'b0;
    slot  = 0;
    for (idx = 0; idx < held_total; idx++) begin
      if (!found && held_keys[idx] == key) begin
        found = 1'b1;
        slot  = idx;
      end
    end
    outcome.is_member = found;
    outcome.status    = ST_OK;
    case (cmd)
      CMD_INSERT: begin
        // duplicate wins over full
        if (found) begin
          outcome.status = ST_DUP;
        end else if (held_total >= SET_DEPTH) begin
          outcome.status = ST_FULL;
        end else begin
          held_keys.push_back(key);
          held_total++;
        end
      end
      CMD_REMOVE: begin
        if (!found) begin
          outcome.status = ST_ABSENT;
        end else begin
          // swap-remove: last entry fills the hole
          held_keys[slot] = held_keys[held_total - 1];
          void'(held_keys.pop_back());
          held_total--;
        end
      end
      default: ;
    endcase
    outcome.entry_count = COUNT_W'(held_total);
    return outcome;
  endfunction

  // Present one request, honoring the burst/gap pattern, and wait for accept
  task automatic send_request(input logic [CMD_W-1:0] cmd,
                              input logic [KEY_W-1:0] key);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    key_i      <= key;
    do @(posedge clk_i); while (in_stall_o);
    outcome_fifo.push_back(key_op_outcome(cmd, key));
  endtask

  // Stop sending until every outstanding result has come back
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outcome_fifo.size() != 0);
  endtask

  // Query and remove on an empty set
  task automatic empty_set_test();
    send_request(CMD_QUERY, '0);
    send_request(CMD_REMOVE, '1);
  endtask

  // Extreme keys, duplicate insert, unused command, swap and last-entry remove
  task automatic basic_ops_test();
    send_request(CMD_INSERT, '0);
    send_request(CMD_INSERT, '1);
    send_request(CMD_INSERT, '0);
    send_request(CMD_SPARE, '1);
    send_request(CMD_REMOVE, '0);
    send_request(CMD_QUERY, '0);
    send_request(CMD_REMOVE, '1);
  endtask

  // Fill the set, then insert into it while full, new key and duplicate
  task automatic full_set_test();
    int unsigned idx;
    for (idx = 0; idx < SET_DEPTH; idx++) begin
      send_request(CMD_INSERT, 32'h5A5A_5A00 + idx);
    end
    send_request(CMD_INSERT, 32'h1234_5678);
    send_request(CMD_INSERT, 32'h5A5A_5A00);
  endtask

  // Random mix drawn mostly from a small key pool so hits and fills happen
  task automatic random_walk_test(input int unsigned n_items,
                                  input int unsigned pool_size,
                                  input int unsigned insert_pct,
                                  input int unsigned remove_pct);
    logic [KEY_W-1:0] key_pool [$];
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    int unsigned      roll;
    int unsigned      idx;
    // pool: some held keys, the extremes, near neighbors and fresh keys
    for (idx = 0; idx < pool_size; idx++) begin
      if (idx < held_total && idx < pool_size / 2) begin
        key_pool.push_back(held_keys[idx]);
      end else if (idx == pool_size - 1) begin
        key_pool.push_back('1);
      end else if (idx == pool_size - 2) begin
        key_pool.push_back('0);
      end else if (idx % 3 == 2) begin
        key_pool.push_back(key_pool[idx - 1] ^ (32'd1 << $urandom_range(0, KEY_W - 1)));
      end else begin
        key_pool.push_back($urandom());
      end
    end
    for (idx = 0; idx < n_items; idx++) begin
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) begin
        cmd = CMD_INSERT;
      end else if (roll < insert_pct + remove_pct) begin
        cmd = CMD_REMOVE;
      end else if (roll < 95) begin
        cmd = CMD_QUERY;
      end else begin
        cmd = CMD_SPARE;
      end
      if ($urandom_range(0, 99) < 85) begin
        key = key_pool[$urandom_range(0, pool_size - 1)];
      end else begin
        key = $urandom();
      end
      send_request(cmd, key);
      if ($urandom_range(0, 149) == 0) begin
        hold_until_drained();
      end
    end
  endtask

  // Receiver stall pattern: free-running, random light, random heavy, periodic
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(50, 300);
    end
    stall_span--;
    stall_tick++;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 99) < 35);
      2:       out_stall_i <= ($urandom_range(0, 99) < 80);
      default: out_stall_i <= ((stall_tick % 16) < 12);
    endcase
  end

  // Compare each accepted result with the oldest outstanding one
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (outcome_fifo.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = outcome_fifo.pop_front();
        if (is_member_o !== want.is_member) begin
          $error("is_member: expected %0d, actual %0d", want.is_member, is_member_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          fail_count++;
        end
        if (entry_count_o !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count, entry_count_o);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned waited;
    in_valid_i  <= 1'b0;
    cmd_i       <= CMD_QUERY;
    key_i       <= '0;
    out_stall_i <= 1'b0;
    rst_ni      <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    empty_set_test();
    basic_ops_test();
    full_set_test();
    hold_until_drained();
    random_walk_test(260, 24, 45, 35);
    hold_until_drained();
    random_walk_test(200, 20, 65, 20);
    hold_until_drained();
    random_walk_test(200, 32, 25, 55);
    hold_until_drained();
    random_walk_test(190, 6, 40, 40);

    // drain outstanding results, then watch for strays
    in_valid_i <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (outcome_fifo.size() != 0 && waited < MAX_DRAIN_WAIT);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (outcome_fifo.size() != 0) begin
      $error("%0d results never arrived", outcome_fifo.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
